>>> src/assert_macros.svh
// Assertion macros shared by the ordered list RTL.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge while reset is low.
`define OLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, including during reset.
`define OLI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define OLI_ASSERT(label, prop, msg)
`define OLI_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> src/oli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list package
// Types, codes and constants shared by the ordered list cells and top level.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // Operation requested by a command transaction.
  typedef enum logic [KIND_W-1:0] {
    OP_APPEND = 3'd0,
    OP_DROP   = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SEARCH = 3'd4
  } kind_t;

  // Completion status of a response transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Update broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic              take;
    cell_op_t          op;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } res_t;

endpackage

>>> src/oli_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, loads from the command or a neighbor, and registers
// whether it holds the searched word.
// ----------------------------------------------------------------------------
module oli_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 7
) (
  input  logic                      clk,
  input  oli_pkg::cell_ctrl_t       ctrl,
  input  logic [IW-1:0]             pos,
  input  logic [IW-1:0]             count,
  input  logic [oli_pkg::WORD_W-1:0] left,
  input  logic [oli_pkg::WORD_W-1:0] right,
  output logic [oli_pkg::WORD_W-1:0] word,
  output logic                      match
);
  import oli_pkg::*;

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic [WORD_W-1:0] word_next;

  // Pick the new entry for this place in the row.
  always_comb begin
    word_next = word;
    case (ctrl.op)
      CELL_APPEND: begin
        if (IDX == count) word_next = ctrl.value;
      end
      CELL_INSERT: begin
        if (IDX == pos) begin
          word_next = ctrl.value;
        end else if (IDX > pos && IDX <= count) begin
          word_next = left;
        end
      end
      CELL_REMOVE: begin
        if (IDX >= pos) word_next = right;
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // Entry storage and the compare result of the accepted transaction.
  always_ff @(posedge clk) begin
    word <= word_next;
    if (ctrl.take) begin
      match <= (IDX < count) && (word == ctrl.value);
    end
  end

endmodule

>>> src/ordered_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list with insert and remove
// Bounded list of 32-bit words kept in a row of cells that shift together.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Payload | Direction
// cmd     | cmd_valid, cmd_ready | cmd_t   | in
// res     | res_valid, res_ready | res_t   | out
//
// A command is accepted only while the cell stage is empty; its response passes
// from the cell stage register into the output register. Each cell registers
// its match bit on acceptance, and the bits are OR-reduced as the stage moves.
// Reset clears the count and both valid flags; entries are not cleared.
// A stalled response holds the output register, and the next command is
// still accepted while it waits there.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove #(
  parameter int DEPTH = oli_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  oli_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output oli_pkg::res_t res
);
  import oli_pkg::*;

`include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  status_t           status_next;
  cell_ctrl_t        ctrl;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     count_x;
  logic              acc;
  logic              s1_move;
  logic              s1_valid;
  status_t           s1_status;
  logic              s1_search;
  logic [CW-1:0]     s1_count;
  logic [WORD_W-1:0] word [DEPTH];
  logic [WORD_W-1:0] left_w [DEPTH];
  logic [WORD_W-1:0] right_w [DEPTH];
  logic [DEPTH-1:0]  match;

  // Handshakes: one transaction at a time in the cell stage.
  assign cmd_ready = !s1_valid;
  assign acc       = cmd_valid && cmd_ready;
  assign s1_move   = s1_valid && (!res_valid || res_ready);

  // Decode the command into a cell update, a status and the new count.
  always_comb begin
    pos_x       = XW'(cmd.position);
    count_x     = XW'(count);
    ctrl.take   = acc;
    ctrl.op     = CELL_HOLD;
    ctrl.value  = cmd.value;
    status_next = ST_DONE;
    count_next  = count;
    if (acc) begin
      case (kind_t'(cmd.kind))
        OP_APPEND: begin
          if (count_x >= XW'(DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_APPEND;
            count_next = count + CW'(1);
          end
        end
        OP_DROP: begin
          if (count == '0) begin
            status_next = ST_BAD;
          end else begin
            count_next = count - CW'(1);
          end
        end
        OP_INSERT: begin
          if (pos_x > count_x) begin
            status_next = ST_BAD;
          end else if (count_x >= XW'(DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_INSERT;
            count_next = count + CW'(1);
          end
        end
        OP_REMOVE: begin
          if (pos_x >= count_x) begin
            status_next = ST_BAD;
          end else begin
            ctrl.op    = CELL_REMOVE;
            count_next = count - CW'(1);
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  // Row of cells wired to neighbors; cell 0 gets the command value as left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = ctrl.value;
    end else begin : g_mid_l
      assign left_w[i] = word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w[i] = word[i];
    end else begin : g_mid_r
      assign right_w[i] = word[i+1];
    end

    oli_cell #(
      .INDEX(i),
      .IW   (XW)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .pos  (pos_x),
      .count(count_x),
      .left (left_w[i]),
      .right(right_w[i]),
      .word (word[i]),
      .match(match[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers: cell stage and response register.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status <= status_next;
      s1_search <= (kind_t'(cmd.kind) == OP_SEARCH);
      s1_count  <= count_next;
    end
    if (s1_move) begin
      res.status   <= s1_status;
      res.found    <= s1_search && (|match);
      res.count    <= COUNT_W'(s1_count);
      res.is_empty <= (s1_count == '0);
    end
  end

  `OLI_ASSERT(a_count_bound, count <= CW'(DEPTH), "count exceeds capacity")
  `OLI_ASSERT(a_search_keeps_count, acc && (kind_t'(cmd.kind) == OP_SEARCH) |=> count == $past(count), "search changed the count")
  `OLI_ASSERT(a_append_grows, acc && (kind_t'(cmd.kind) == OP_APPEND) && (count_x < XW'(DEPTH)) |=> count == $past(count) + CW'(1), "append did not grow the list")
  `OLI_ASSERT(a_accept_fills_stage, acc |=> s1_valid, "accepted command lost")
  `OLI_ASSERT(a_response_from_stage, !$past(s1_valid) && !$past(rst) && $rose(res_valid) |-> 1'b0, "response without a command")

endmodule
